// ===== rtl/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg
// Types, widths and constants shared by the rotation matrix to quaternion
// pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

    // fixed-point format of matrix and quaternion values
    localparam int FRAC_BITS = 14;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int Q_ONE     = (ONE > 32767) ? 32767 : ONE;

    // datapath widths
    localparam int CW       = 18;              // signed component width
    localparam int MW       = CW - 1;          // component magnitude width
    localparam int PW       = 2 * MW;          // square width
    localparam int SW       = PW + 2;          // sum of four squares
    localparam int RW       = SW / 2;          // square root width
    localparam int RMW      = RW + 3;          // root remainder width
    localparam int NW       = MW + FRAC_BITS + 1; // dividend width
    localparam int QW       = FRAC_BITS + 1;   // quotient width
    localparam int SQ_STEPS = RW;              // one root bit per stage
    localparam int DV_STEPS = QW;              // one quotient bit per stage

    // case codes
    localparam logic [1:0] CASE_TRACE = 2'd0;
    localparam logic [1:0] CASE_X     = 2'd1;
    localparam logic [1:0] CASE_Y     = 2'd2;
    localparam logic [1:0] CASE_Z     = 2'd3;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
    } mat_t;

    typedef struct packed {
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic [1:0]         case_taken;
    } quat_t;

    // component magnitudes, signs and case code that ride along the root pipeline
    typedef struct packed {
        logic [3:0][MW-1:0] mag;
        logic [3:0]         neg;
        logic [1:0]         sel;
    } side_t;

    typedef struct packed {
        logic [SW-1:0]  s;
        logic [RMW-1:0] rem;
        logic [RW-1:0]  root;
        side_t          side;
        logic           zero;
    } sqrt_t;

    typedef struct packed {
        logic [3:0][NW-1:0] pr;
        logic [NW-1:0]      d;
        logic [3:0][QW-1:0] q;
        logic [3:0]         neg;
        logic [1:0]         sel;
        logic               zero;
    } div_t;

endpackage

// ===== rtl/rmq_front.sv =====
// ----------------------------------------------------------------------------
// rmq_front
// Case selection, unnormalized components, squares and their sum in three
// register stages.
// ----------------------------------------------------------------------------
module rmq_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                vld_in,
    input  rmq_pkg::mat_t       mat_in,
    output logic                vld_out,
    output rmq_pkg::sqrt_t      st_out
);

    logic signed [rmq_pkg::CW-1:0] c_next [4];
    logic signed [rmq_pkg::CW-1:0] c_reg  [4];
    logic [1:0]                    sel_next;
    logic [1:0]                    sel_reg;
    logic                          vld_a_reg;

    logic [3:0][rmq_pkg::MW-1:0]   mag_next;
    logic [3:0][rmq_pkg::MW-1:0]   mag_reg;
    logic [3:0][rmq_pkg::PW-1:0]   sq_next;
    logic [3:0][rmq_pkg::PW-1:0]   sq_reg;
    logic [3:0]                    neg_next;
    logic [3:0]                    neg_reg;
    logic [1:0]                    sel_b_reg;
    logic                          vld_b_reg;

    logic [rmq_pkg::SW-1:0]        sum_next;
    rmq_pkg::sqrt_t                st_reg;
    logic                          vld_c_reg;

    // stage a: case select and components
    always_comb
    begin
        logic signed [rmq_pkg::CW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
        logic signed [rmq_pkg::CW-1:0] tr, one;
        e00 = rmq_pkg::CW'(mat_in.m00);
        e01 = rmq_pkg::CW'(mat_in.m01);
        e02 = rmq_pkg::CW'(mat_in.m02);
        e10 = rmq_pkg::CW'(mat_in.m10);
        e11 = rmq_pkg::CW'(mat_in.m11);
        e12 = rmq_pkg::CW'(mat_in.m12);
        e20 = rmq_pkg::CW'(mat_in.m20);
        e21 = rmq_pkg::CW'(mat_in.m21);
        e22 = rmq_pkg::CW'(mat_in.m22);
        one = rmq_pkg::CW'(rmq_pkg::ONE);
        tr  = e00 + e11 + e22;
        if (tr > 0)
            sel_next = rmq_pkg::CASE_TRACE;
        else if (e00 > e11 && e00 > e22)
            sel_next = rmq_pkg::CASE_X;
        else if (e11 > e22)
            sel_next = rmq_pkg::CASE_Y;
        else
            sel_next = rmq_pkg::CASE_Z;
        case (sel_next)
            rmq_pkg::CASE_TRACE:
            begin
                c_next[0] = e12 - e21;
                c_next[1] = e20 - e02;
                c_next[2] = e01 - e10;
                c_next[3] = tr + one;
            end
            rmq_pkg::CASE_X:
            begin
                c_next[0] = one + e00 - e11 - e22;
                c_next[1] = e10 + e01;
                c_next[2] = e20 + e02;
                c_next[3] = e12 - e21;
            end
            rmq_pkg::CASE_Y:
            begin
                c_next[0] = e10 + e01;
                c_next[1] = one + e11 - e00 - e22;
                c_next[2] = e21 + e12;
                c_next[3] = e20 - e02;
            end
            default:
            begin
                c_next[0] = e20 + e02;
                c_next[1] = e21 + e12;
                c_next[2] = one + e22 - e00 - e11;
                c_next[3] = e01 - e10;
            end
        endcase
    end

    // stage b: magnitudes and squares
    always_comb
    begin
        logic [rmq_pkg::CW-1:0] t;
        for (int i = 0; i < 4; i++)
        begin
            neg_next[i] = c_reg[i][rmq_pkg::CW-1];
            t           = neg_next[i] ? rmq_pkg::CW'(-c_reg[i]) : rmq_pkg::CW'(c_reg[i]);
            mag_next[i] = t[rmq_pkg::MW-1:0];
            sq_next[i]  = rmq_pkg::PW'(mag_next[i]) * rmq_pkg::PW'(mag_next[i]);
        end
    end

    // stage c: sum of squares
    assign sum_next = rmq_pkg::SW'(sq_reg[0]) + rmq_pkg::SW'(sq_reg[1])
                    + rmq_pkg::SW'(sq_reg[2]) + rmq_pkg::SW'(sq_reg[3]);

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_a_reg <= vld_in;
            vld_b_reg <= vld_a_reg;
            vld_c_reg <= vld_b_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg          <= c_next;
            sel_reg        <= sel_next;
            mag_reg        <= mag_next;
            sq_reg         <= sq_next;
            neg_reg        <= neg_next;
            sel_b_reg      <= sel_reg;
            st_reg.s       <= sum_next;
            st_reg.rem     <= '0;
            st_reg.root    <= '0;
            st_reg.side    <= '{mag: mag_reg, neg: neg_reg, sel: sel_b_reg};
            st_reg.zero    <= (sum_next == '0);
        end
    end

    assign vld_out = vld_c_reg;
    assign st_out  = st_reg;

endmodule

// ===== rtl/rmq_sqrt_step.sv =====
// ----------------------------------------------------------------------------
// rmq_sqrt_step
// One registered step of the digit-by-digit integer square root: brings in
// two bits of the radicand and decides one root bit.
// ----------------------------------------------------------------------------
module rmq_sqrt_step (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            vld_in,
    input  rmq_pkg::sqrt_t  st_in,
    output logic            vld_out,
    output rmq_pkg::sqrt_t  st_out
);

    rmq_pkg::sqrt_t st_next;
    rmq_pkg::sqrt_t st_reg;
    logic           vld_reg;

    // trial subtract of 4r+1 from the shifted remainder
    always_comb
    begin
        logic [rmq_pkg::RMW-1:0] remx;
        logic [rmq_pkg::RMW-1:0] trial;
        remx    = {st_in.rem[rmq_pkg::RMW-3:0], st_in.s[rmq_pkg::SW-1 -: 2]};
        trial   = rmq_pkg::RMW'({st_in.root, 2'b01});
        st_next = st_in;
        st_next.s = {st_in.s[rmq_pkg::SW-3:0], 2'b00};
        if (remx >= trial)
        begin
            st_next.rem  = remx - trial;
            st_next.root = {st_in.root[rmq_pkg::RW-2:0], 1'b1};
        end
        else
        begin
            st_next.rem  = remx;
            st_next.root = {st_in.root[rmq_pkg::RW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            st_reg <= st_next;
    end

    assign vld_out = vld_reg;
    assign st_out  = st_reg;

endmodule

// ===== rtl/rmq_div_step.sv =====
// ----------------------------------------------------------------------------
// rmq_div_step
// One registered restoring-division step for all four lanes against the
// shared root; the divisor shifts right one place per step.
// ----------------------------------------------------------------------------
module rmq_div_step (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           vld_in,
    input  rmq_pkg::div_t  st_in,
    output logic           vld_out,
    output rmq_pkg::div_t  st_out
);

    rmq_pkg::div_t st_next;
    rmq_pkg::div_t st_reg;
    logic          vld_reg;

    // compare and subtract per lane
    always_comb
    begin
        st_next = st_in;
        for (int i = 0; i < 4; i++)
        begin
            if (st_in.pr[i] >= st_in.d)
            begin
                st_next.pr[i] = st_in.pr[i] - st_in.d;
                st_next.q[i]  = {st_in.q[i][rmq_pkg::QW-2:0], 1'b1};
            end
            else
            begin
                st_next.q[i]  = {st_in.q[i][rmq_pkg::QW-2:0], 1'b0};
            end
        end
        st_next.d = st_in.d >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            st_reg <= st_next;
    end

    assign vld_out = vld_reg;
    assign st_out  = st_reg;

endmodule

// ===== rtl/rotation_matrix_to_quaternion.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Converts a Q1.14 rotation matrix to a normalized Q1.14 quaternion through
// a fully pipelined square root and four-lane divider.
// ----------------------------------------------------------------------------
//  channel   handshake               payload   direction
//  mat       mat_valid / mat_ready   mat_t     in
//  quat      quat_valid / quat_ready quat_t    out
//
//  one matrix per cycle while not held; stages: 3 front, 18 root, 1 setup,
//  15 divide, 1 output, set by the one-bit-per-stage root and divider
//  the whole pipeline advances together; it holds when the output register
//  is full and quat_ready is low, and mat_ready follows that enable
//  reset clears every valid bit; payload registers are not reset
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           mat_valid,
    output logic           mat_ready,
    input  rmq_pkg::mat_t  mat,
    output logic           quat_valid,
    input  logic           quat_ready,
    output rmq_pkg::quat_t quat
);

    logic                en;
    logic                sq_vld [rmq_pkg::SQ_STEPS+1];
    rmq_pkg::sqrt_t      sq_st  [rmq_pkg::SQ_STEPS+1];
    logic                dv_vld [rmq_pkg::DV_STEPS+1];
    rmq_pkg::div_t       dv_st  [rmq_pkg::DV_STEPS+1];
    rmq_pkg::div_t       init_next;
    rmq_pkg::div_t       init_reg;
    logic                init_vld_reg;
    rmq_pkg::quat_t      out_next;
    rmq_pkg::quat_t      out_reg;
    logic                out_vld_reg;

    // pipeline moves when the output register is empty or being drained
    assign en        = !out_vld_reg || quat_ready;
    assign mat_ready = en;

    rmq_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (mat_valid),
        .mat_in  (mat),
        .vld_out (sq_vld[0]),
        .st_out  (sq_st[0])
    );

    // square root, one bit per stage
    for (genvar g = 0; g < rmq_pkg::SQ_STEPS; g++)
    begin : g_sqrt
        rmq_sqrt_step u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .vld_in  (sq_vld[g]),
            .st_in   (sq_st[g]),
            .vld_out (sq_vld[g+1]),
            .st_out  (sq_st[g+1])
        );
    end

    // divider setup: rounded dividends and aligned divisor
    always_comb
    begin
        rmq_pkg::sqrt_t s;
        s = sq_st[rmq_pkg::SQ_STEPS];
        for (int i = 0; i < 4; i++)
        begin
            init_next.pr[i] = (rmq_pkg::NW'(s.side.mag[i]) << rmq_pkg::FRAC_BITS)
                            + rmq_pkg::NW'(s.root >> 1);
        end
        init_next.d    = rmq_pkg::NW'(s.root) << (rmq_pkg::QW - 1);
        init_next.q    = '0;
        init_next.neg  = s.side.neg;
        init_next.sel  = s.side.sel;
        init_next.zero = s.zero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            init_vld_reg <= 1'b0;
        else if (en)
            init_vld_reg <= sq_vld[rmq_pkg::SQ_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            init_reg <= init_next;
    end

    assign dv_vld[0] = init_vld_reg;
    assign dv_st[0]  = init_reg;

    // division, one quotient bit per stage
    for (genvar g = 0; g < rmq_pkg::DV_STEPS; g++)
    begin : g_div
        rmq_div_step u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .vld_in  (dv_vld[g]),
            .st_in   (dv_st[g]),
            .vld_out (dv_vld[g+1]),
            .st_out  (dv_st[g+1])
        );
    end

    // sign restore and identity on zero length
    always_comb
    begin
        rmq_pkg::div_t d;
        logic [15:0]   v [4];
        d = dv_st[rmq_pkg::DV_STEPS];
        for (int i = 0; i < 4; i++)
        begin
            v[i] = d.neg[i] ? (~16'(d.q[i]) + 16'd1) : 16'(d.q[i]);
        end
        if (d.zero)
        begin
            out_next.quat_x = '0;
            out_next.quat_y = '0;
            out_next.quat_z = '0;
            out_next.quat_w = 16'(rmq_pkg::Q_ONE);
        end
        else
        begin
            out_next.quat_x = v[0];
            out_next.quat_y = v[1];
            out_next.quat_z = v[2];
            out_next.quat_w = v[3];
        end
        out_next.case_taken = d.sel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= dv_vld[rmq_pkg::DV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= out_next;
    end

    assign quat_valid = out_vld_reg;
    assign quat       = out_reg;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for rotation_matrix_to_quaternion. A directed table of
// matrices (identity, axis flips, extremes, ties) is followed by random
// matrices sent in bursts. Every transfer out is compared field by field with
// a quaternion predicted in the bench, while the receiver stalls on its own
// pattern and twice holds off long enough to back up the whole pipeline.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int  N_RANDOM   = 1300;
    localparam int  DRAIN      = 60;
    localparam int  CYCLE_CAP  = 600000;

    typedef struct {
        rmq_pkg::mat_t  m;
        bit             known;
        rmq_pkg::quat_t q;
    } row_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           mat_valid = 1'b0;
    logic           mat_ready;
    rmq_pkg::mat_t  mat = '0;
    logic           quat_valid;
    logic           quat_ready = 1'b0;
    rmq_pkg::quat_t quat;

    rmq_pkg::quat_t quat_expected[$];
    row_t  dir_rows[$];
    int    mismatches = 0;
    int    cycles = 0;
    bit    took = 1'b0;

    rotation_matrix_to_quaternion dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .mat_valid  (mat_valid),
        .mat_ready  (mat_ready),
        .mat        (mat),
        .quat_valid (quat_valid),
        .quat_ready (quat_ready),
        .quat       (quat)
    );

    // clock
    always #6 clk = ~clk;

    // floor of the square root
    function automatic longint root_floor(longint s);
        longint r;
        longint b;
        r = 0;
        b = longint'(1) << 62;
        while (b > s)
            b = b >>> 2;
        while (b != 0)
        begin
            if (s >= r + b)
            begin
                s = s - (r + b);
                r = (r >>> 1) + b;
            end
            else
                r = r >>> 1;
            b = b >>> 2;
        end
        return r;
    endfunction

    // predicted quaternion for one matrix
    function automatic rmq_pkg::quat_t quat_of(rmq_pkg::mat_t m);
        longint a00, a01, a02, a10, a11, a12, a20, a21, a22;
        longint c[4];
        longint one, tr, s, r, mg, q, v;
        logic [15:0] o[4];
        logic [1:0] sel;
        rmq_pkg::quat_t res;
        a00 = m.m00; a01 = m.m01; a02 = m.m02;
        a10 = m.m10; a11 = m.m11; a12 = m.m12;
        a20 = m.m20; a21 = m.m21; a22 = m.m22;
        one = longint'(1) << rmq_pkg::FRAC_BITS;
        tr = a00 + a11 + a22;
        if (tr > 0)
        begin
            sel = rmq_pkg::CASE_TRACE;
            c[0] = a12 - a21; c[1] = a20 - a02; c[2] = a01 - a10; c[3] = tr + one;
        end
        else if (a00 > a11 && a00 > a22)
        begin
            sel = rmq_pkg::CASE_X;
            c[0] = one + a00 - a11 - a22; c[1] = a10 + a01;
            c[2] = a20 + a02; c[3] = a12 - a21;
        end
        else if (a11 > a22)
        begin
            sel = rmq_pkg::CASE_Y;
            c[0] = a10 + a01; c[1] = one + a11 - a00 - a22;
            c[2] = a21 + a12; c[3] = a20 - a02;
        end
        else
        begin
            sel = rmq_pkg::CASE_Z;
            c[0] = a20 + a02; c[1] = a21 + a12;
            c[2] = one + a22 - a00 - a11; c[3] = a01 - a10;
        end
        s = 0;
        for (int i = 0; i < 4; i++)
            s += c[i] * c[i];
        if (s == 0)
        begin
            o[0] = '0; o[1] = '0; o[2] = '0;
            o[3] = (one > 32767) ? 16'sd32767 : one[15:0];
        end
        else
        begin
            r = root_floor(s);
            for (int i = 0; i < 4; i++)
            begin
                mg = (c[i] < 0) ? -c[i] : c[i];
                q = ((mg << rmq_pkg::FRAC_BITS) + (r >>> 1)) / r;
                if (q > 32768)
                    q = 32768;
                v = (c[i] < 0) ? -q : q;
                if (v > 32767)
                    v = 32767;
                o[i] = v[15:0];
            end
        end
        res.quat_x = o[0];
        res.quat_y = o[1];
        res.quat_z = o[2];
        res.quat_w = o[3];
        res.case_taken = sel;
        return res;
    endfunction

    function automatic rmq_pkg::mat_t mk(int a, int b, int c, int d, int e, int f, int g,
                                         int h, int k);
        rmq_pkg::mat_t m;
        m.m00 = a[15:0]; m.m01 = b[15:0]; m.m02 = c[15:0];
        m.m10 = d[15:0]; m.m11 = e[15:0]; m.m12 = f[15:0];
        m.m20 = g[15:0]; m.m21 = h[15:0]; m.m22 = k[15:0];
        return m;
    endfunction

    function automatic rmq_pkg::quat_t qk(int x, int y, int z, int w, logic [1:0] c);
        rmq_pkg::quat_t q;
        q.quat_x = x[15:0]; q.quat_y = y[15:0]; q.quat_z = z[15:0];
        q.quat_w = w[15:0]; q.case_taken = c;
        return q;
    endfunction

    function automatic void add_row(rmq_pkg::mat_t m, bit known, rmq_pkg::quat_t q);
        row_t r;
        r.m = m;
        r.known = known;
        r.q = q;
        dir_rows.push_back(r);
    endfunction

    // one random matrix element, biased toward rotation-sized values
    function automatic logic [15:0] rand_elem(int kind);
        int v;
        case (kind)
            0: v = $urandom;
            1: v = $urandom_range(0, 32768) - 16384;
            2:
            begin
                case ($urandom_range(0, 5))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = 16384;
                    3: v = -16384;
                    4: v = 0;
                    default: v = $urandom_range(0, 8) - 4;
                endcase
            end
            default: v = $urandom_range(0, 2048) - 1024;
        endcase
        return v[15:0];
    endfunction

    function automatic rmq_pkg::mat_t rand_mat();
        rmq_pkg::mat_t m;
        int kind;
        kind = ($urandom_range(0, 9) < 6) ? 1 : $urandom_range(0, 3);
        m.m00 = rand_elem(kind); m.m01 = rand_elem(kind); m.m02 = rand_elem(kind);
        m.m10 = rand_elem(kind); m.m11 = rand_elem(kind); m.m12 = rand_elem(kind);
        m.m20 = rand_elem(kind); m.m21 = rand_elem(kind); m.m22 = rand_elem(kind);
        // force diagonal ties now and then
        case ($urandom_range(0, 7))
            0: m.m11 = m.m00;
            1: m.m22 = m.m11;
            2: m.m22 = m.m00;
            3: begin m.m11 = m.m00; m.m22 = m.m00; end
            default: ;
        endcase
        return m;
    endfunction

    // one transfer in; expectation is queued at acceptance
    task automatic send_mat(rmq_pkg::mat_t m, rmq_pkg::quat_t q);
        mat = m;
        mat_valid = 1'b1;
        do
            @(negedge clk);
        while (!took);
        quat_expected.push_back(q);
    endtask

    // input acceptance flag, seen by the driver at the next falling edge
    always @(posedge clk)
        took = mat_valid && mat_ready;

    // cycle counter and timeout
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver stall pattern, with two long hold-offs
    initial
    begin : receiver
        int mode;
        int hold;
        mode = 0;
        hold = 0;
        while (1)
        begin
            @(negedge clk);
            if (cycles % 97 == 0)
                mode = $urandom_range(0, 4);
            if (cycles == 400 || cycles == 6000)
                hold = 250;
            if (hold > 0)
            begin
                hold--;
                quat_ready = 1'b0;
            end
            else
            begin
                case (mode)
                    0: quat_ready = 1'b1;
                    1: quat_ready = 1'($urandom_range(0, 1));
                    2: quat_ready = ($urandom_range(0, 3) == 0);
                    3: quat_ready = (cycles % 8) < 5;
                    default: quat_ready = ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // output check
    always @(posedge clk)
    begin
        rmq_pkg::quat_t e;
        if (quat_valid && quat_ready)
        begin
            if (quat_expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer out: %p", quat);
            end
            else
            begin
                e = quat_expected.pop_front();
                if (quat.quat_x !== e.quat_x || quat.quat_y !== e.quat_y ||
                    quat.quat_z !== e.quat_z || quat.quat_w !== e.quat_w ||
                    quat.case_taken !== e.case_taken)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp x=%0d y=%0d z=%0d w=%0d c=%0d",
                                  " got x=%0d y=%0d z=%0d w=%0d c=%0d"},
                                 e.quat_x, e.quat_y, e.quat_z, e.quat_w, e.case_taken,
                                 quat.quat_x, quat.quat_y, quat.quat_z, quat.quat_w,
                                 quat.case_taken);
                end
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        int burst;
        int gap;
        rmq_pkg::mat_t m;
        rmq_pkg::quat_t none;
        none = '0;

        // directed table: identity, half turns about each axis, zero, extremes, ties
        add_row(mk(16384, 0, 0, 0, 16384, 0, 0, 0, 16384), 1,
                qk(0, 0, 0, 16384, rmq_pkg::CASE_TRACE));
        add_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, qk(0, 0, 16384, 0, rmq_pkg::CASE_Z));
        add_row(mk(16384, 0, 0, 0, -16384, 0, 0, 0, -16384), 1,
                qk(16384, 0, 0, 0, rmq_pkg::CASE_X));
        add_row(mk(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384), 1,
                qk(0, 16384, 0, 0, rmq_pkg::CASE_Y));
        add_row(mk(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384), 1,
                qk(0, 0, 16384, 0, rmq_pkg::CASE_Z));
        add_row(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                   -32768), 0, none);
        add_row(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767),
                0, none);
        add_row(mk(32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768,
                   32767), 0, none);
        add_row(mk(-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767,
                   -32768), 0, none);
        add_row(mk(0, 16384, 0, -16384, 0, 0, 0, 0, 16384), 0, none);
        // trace exactly zero
        add_row(mk(8192, 1000, -2000, 3000, -4096, 500, -700, 900, -4096), 0, none);
        // diagonal ties
        add_row(mk(0, 100, 200, 300, 0, 400, 500, 600, -16384), 0, none);
        add_row(mk(-8192, 1, 2, 3, -8192, 4, 5, 6, -8192), 0, none);
        add_row(mk(-4096, 7, 8, 9, -8192, 10, 11, 12, -8192), 0, none);
        add_row(mk(-8192, 13, 14, 15, -4096, 16, 17, 18, -4096), 0, none);
        add_row(mk(11585, -11585, 0, 11585, 11585, 0, 0, 0, 16384), 0, none);
        add_row(mk(1, 0, 0, 0, 0, 0, 0, 0, -1), 0, none);

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_mat(dir_rows[i].m, dir_rows[i].known ? dir_rows[i].q
                                                      : quat_of(dir_rows[i].m));

        // random part in bursts
        burst = 0;
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (burst == 0)
            begin
                burst = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 20);
                gap = $urandom_range(0, 12);
                if (gap > 0)
                begin
                    mat_valid = 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            burst--;
            m = rand_mat();
            send_mat(m, quat_of(m));
        end
        mat_valid = 1'b0;

        while (quat_expected.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);

        if (mismatches == 0 && quat_expected.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
